// File: hw/rtl/tcsd_pkg.sv
// ----------------------------------------------------------------------------
// Three-circle signed distance: shared package
// Types, field layout, register indexes and output limits used by all files.
// ----------------------------------------------------------------------------
`default_nettype none

package tcsd_pkg;

   localparam int NUM_CIRCLES = 3;
   localparam int FIELD_BITS  = 16;
   localparam int CIRCLE_BITS = 48;
   localparam int OUT_BITS    = 18;
   localparam int OUT_MAX     = 131071;
   localparam int OUT_MIN     = -131072;
   localparam int CSR_IDX_BITS = 2;

   // Packed circle register: centre x, centre y (signed), radius (unsigned).
   typedef struct packed {
      logic [FIELD_BITS-1:0] cx;
      logic [FIELD_BITS-1:0] cy;
      logic [FIELD_BITS-1:0] radius;
   } circle_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CIRCLE_A = 2'd0,
      CSR_CIRCLE_B = 2'd1,
      CSR_CIRCLE_C = 2'd2,
      CSR_INVERT   = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

// File: hw/rtl/tcsd_front.sv
// ----------------------------------------------------------------------------
// Three-circle signed distance: front end
// Forms centre-minus-point magnitudes, then the sum of squares per circle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsd_front #(
   parameter int CW = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_hold,
   input  logic [tcsd_pkg::FIELD_BITS-1:0]              point_x,
   input  logic [tcsd_pkg::FIELD_BITS-1:0]              point_y,
   input  tcsd_pkg::circle_type [tcsd_pkg::NUM_CIRCLES-1:0] circles,
   output logic                                        out_valid,
   input  logic                                        out_hold,
   output logic [tcsd_pkg::NUM_CIRCLES-1:0][2*CW+1:0]   out_sum,
   output logic                                        full
);
   import tcsd_pkg::*;

   localparam int SW = 2*CW + 2;

   logic                           a_valid_ff, a_valid_in;
   logic [NUM_CIRCLES-1:0][CW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic                           b_valid_ff, b_valid_in;
   logic [NUM_CIRCLES-1:0][SW-1:0] sum_ff, sum_in;
   logic                           a_hold, b_hold;

   logic signed [CW:0]             px, py;
   logic signed [NUM_CIRCLES-1:0][CW:0] dx, dy;

   assign b_hold  = b_valid_ff & out_hold;
   assign a_hold  = a_valid_ff & b_hold;
   assign in_hold = a_hold;

   // Coordinates are read as CW-bit two's complement from the low field bits.
   assign px = {point_x[CW-1], point_x[CW-1:0]};
   assign py = {point_y[CW-1], point_y[CW-1:0]};

   always_comb begin
      a_valid_in = a_hold ? a_valid_ff : in_valid;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      for (int l = 0; l < NUM_CIRCLES; l++) begin
         dx[l] = $signed({circles[l].cx[CW-1], circles[l].cx[CW-1:0]}) - px;
         dy[l] = $signed({circles[l].cy[CW-1], circles[l].cy[CW-1:0]}) - py;
         if (!a_hold) begin
            ax_in[l] = dx[l][CW] ? CW'(-dx[l]) : dx[l][CW-1:0];
            ay_in[l] = dy[l][CW] ? CW'(-dy[l]) : dy[l][CW-1:0];
         end
      end
   end

   always_comb begin
      b_valid_in = b_hold ? b_valid_ff : a_valid_ff;
      sum_in     = sum_ff;
      if (!b_hold) begin
         for (int l = 0; l < NUM_CIRCLES; l++) begin
            sum_in[l] = SW'((2*CW)'(ax_ff[l]) * (2*CW)'(ax_ff[l]))
                      + SW'((2*CW)'(ay_ff[l]) * (2*CW)'(ay_ff[l]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      sum_ff <= sum_in;
   end

   assign out_valid = b_valid_ff;
   assign out_sum   = sum_ff;
   assign full      = a_valid_ff & b_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tcsd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Three-circle signed distance: square root cell
// One digit step of the restoring square root for all three circles.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsd_sqrt_cell #(
   parameter int RW = 17
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_hold,
   input  logic [tcsd_pkg::NUM_CIRCLES-1:0][2*RW-1:0]   in_sum,
   input  logic [tcsd_pkg::NUM_CIRCLES-1:0][RW+2:0]     in_rem,
   input  logic [tcsd_pkg::NUM_CIRCLES-1:0][RW-1:0]     in_root,
   output logic                                        out_valid,
   input  logic                                        out_hold,
   output logic [tcsd_pkg::NUM_CIRCLES-1:0][2*RW-1:0]   out_sum,
   output logic [tcsd_pkg::NUM_CIRCLES-1:0][RW+2:0]     out_rem,
   output logic [tcsd_pkg::NUM_CIRCLES-1:0][RW-1:0]     out_root
);
   import tcsd_pkg::*;

   localparam int SW  = 2*RW;
   localparam int RMW = RW + 3;

   logic                            valid_ff, valid_in, hold;
   logic [NUM_CIRCLES-1:0][SW-1:0]  sum_ff, sum_in;
   logic [NUM_CIRCLES-1:0][RMW-1:0] rem_ff, rem_in;
   logic [NUM_CIRCLES-1:0][RW-1:0]  root_ff, root_in;
   logic [NUM_CIRCLES-1:0][RMW-1:0] cur, trial;
   logic [NUM_CIRCLES-1:0]          fits;

   assign hold    = valid_ff & out_hold;
   assign in_hold = hold;

   // Bring down the next two bits of the sum and try the next root bit.
   always_comb begin
      valid_in = hold ? valid_ff : in_valid;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      for (int l = 0; l < NUM_CIRCLES; l++) begin
         cur[l]   = {in_rem[l][RMW-3:0], in_sum[l][SW-1 -: 2]};
         trial[l] = {1'b0, in_root[l], 2'b01};
         fits[l]  = cur[l] >= trial[l];
         if (!hold) begin
            sum_in[l]  = {in_sum[l][SW-3:0], 2'b00};
            rem_in[l]  = fits[l] ? cur[l] - trial[l] : cur[l];
            root_in[l] = {in_root[l][RW-2:0], fits[l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tcsd_back.sv
// ----------------------------------------------------------------------------
// Three-circle signed distance: back end
// Subtracts radii, takes the minimum, applies the sign flag and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsd_back #(
   parameter int RW = 17
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_hold,
   input  logic [tcsd_pkg::NUM_CIRCLES-1:0][RW-1:0]     in_root,
   input  tcsd_pkg::circle_type [tcsd_pkg::NUM_CIRCLES-1:0] circles,
   input  logic                                        invert,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [tcsd_pkg::OUT_BITS-1:0]         rsp_distance,
   output logic                                        full
);
   import tcsd_pkg::*;

   localparam int IW = ((RW > FIELD_BITS) ? RW : FIELD_BITS) + 2;
   localparam logic signed [IW-1:0] SAT_HI = IW'(OUT_MAX);
   localparam logic signed [IW-1:0] SAT_LO = IW'(OUT_MIN);

   logic                                  c_valid_ff, c_valid_in, c_hold;
   logic signed [NUM_CIRCLES-1:0][IW-1:0] dist_ff, dist_in;
   logic                                  d_valid_ff, d_valid_in, d_hold;
   logic signed [OUT_BITS-1:0]            out_ff, out_in;
   logic signed [IW-1:0]                  min01, min012, signed_min, clamped;

   assign d_hold  = d_valid_ff & rsp_stall;
   assign c_hold  = c_valid_ff & d_hold;
   assign in_hold = c_hold;

   always_comb begin
      c_valid_in = c_hold ? c_valid_ff : in_valid;
      dist_in    = dist_ff;
      if (!c_hold) begin
         for (int l = 0; l < NUM_CIRCLES; l++) begin
            dist_in[l] = $signed({{(IW-RW){1'b0}}, in_root[l]})
                       - $signed({{(IW-FIELD_BITS){1'b0}}, circles[l].radius});
         end
      end
   end

   // Elements of a packed array read back unsigned, so compare them as signed.
   always_comb begin
      min01      = ($signed(dist_ff[1]) < $signed(dist_ff[0])) ? dist_ff[1] : dist_ff[0];
      min012     = ($signed(dist_ff[2]) < min01) ? dist_ff[2] : min01;
      signed_min = invert ? -min012 : min012;
      if (signed_min > SAT_HI) begin
         clamped = SAT_HI;
      end else if (signed_min < SAT_LO) begin
         clamped = SAT_LO;
      end else begin
         clamped = signed_min;
      end
      d_valid_in = d_hold ? d_valid_ff : c_valid_ff;
      out_in     = d_hold ? out_ff : clamped[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
      dist_ff <= dist_in;
      out_ff  <= out_in;
   end

   assign rsp_valid    = d_valid_ff;
   assign rsp_distance = out_ff;
   assign full         = c_valid_ff & d_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/three_circle_signed_distance_unit.sv
// ----------------------------------------------------------------------------
// Three-circle signed distance unit
// Signed distance from a fixed-point point to the union of three circles.
// ----------------------------------------------------------------------------
// The unit takes one point per clock and returns one distance per clock once
// the pipeline is full, while the output is not stalled. The pipeline has
// two front stages for differences and the sum of squares, one square root
// cell per root bit (capped coordinate width plus one cells), and two back
// stages for radius, minimum, sign and saturation. Each stage holds only when
// it is full and the stage after it holds, so bubbles close up and a new point
// is taken whenever the output register is not stalled.
// Configuration takes effect on points accepted after the write and must only
// be written while the unit is empty.
`default_nettype none

module three_circle_signed_distance_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [tcsd_pkg::FIELD_BITS-1:0] req_point_x,
   input  logic signed [tcsd_pkg::FIELD_BITS-1:0] req_point_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [tcsd_pkg::OUT_BITS-1:0]   rsp_distance,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tcsd_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [tcsd_pkg::CIRCLE_BITS-1:0]       csr_wdata
);
   import tcsd_pkg::*;

   localparam int CW  = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int RW  = CW + 1;
   localparam int SW  = 2*RW;
   localparam int RMW = RW + 3;

   circle_type [NUM_CIRCLES-1:0] circle_ff, circle_in;
   logic                         invert_ff, invert_in;
   csr_index_type                csr_sel;

   logic [RW:0]                           valid_chain, hold_chain;
   logic [RW:0][NUM_CIRCLES-1:0][SW-1:0]  sum_chain;
   logic [RW:0][NUM_CIRCLES-1:0][RMW-1:0] rem_chain;
   logic [RW:0][NUM_CIRCLES-1:0][RW-1:0]  root_chain;
   logic                                  front_full, back_full;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);

   always_comb begin
      circle_in = circle_ff;
      invert_in = invert_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_sel)
            CSR_CIRCLE_A: circle_in[0] = circle_type'(csr_wdata);
            CSR_CIRCLE_B: circle_in[1] = circle_type'(csr_wdata);
            CSR_CIRCLE_C: circle_in[2] = circle_type'(csr_wdata);
            CSR_INVERT:   invert_in    = csr_wdata[0];
            default:      invert_in    = invert_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         circle_ff <= '0;
         invert_ff <= 1'b0;
      end else begin
         circle_ff <= circle_in;
         invert_ff <= invert_in;
      end
   end

   tcsd_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_hold   (req_stall),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .circles   (circle_ff),
      .out_valid (valid_chain[0]),
      .out_hold  (hold_chain[0]),
      .out_sum   (sum_chain[0]),
      .full      (front_full)
   );

   assign rem_chain[0]  = '0;
   assign root_chain[0] = '0;

   for (genvar k = 0; k < RW; k++) begin : g_cell
      tcsd_sqrt_cell #(.RW(RW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[k]),
         .in_hold   (hold_chain[k]),
         .in_sum    (sum_chain[k]),
         .in_rem    (rem_chain[k]),
         .in_root   (root_chain[k]),
         .out_valid (valid_chain[k+1]),
         .out_hold  (hold_chain[k+1]),
         .out_sum   (sum_chain[k+1]),
         .out_rem   (rem_chain[k+1]),
         .out_root  (root_chain[k+1])
      );
   end

   tcsd_back #(.RW(RW)) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (valid_chain[RW]),
      .in_hold      (hold_chain[RW]),
      .in_root      (root_chain[RW]),
      .circles      (circle_ff),
      .invert       (invert_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_distance (rsp_distance),
      .full         (back_full)
   );

   // A stall at the input only ever comes from a stalled result.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while the output register is free");

   // With every stage full and the result held, nothing may enter.
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (front_full && (&valid_chain[RW:1]) && back_full && rsp_stall) |-> req_stall)
      else $error("input accepted into a full, stalled pipeline");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

`default_nettype wire
